/* rtl/line_framer_with_drop_oldest_queue_macros.svh */
// assertion macros shared by the checker of the line framer
// no dependencies; the checker includes this file by its bare name
`ifndef LINE_FRAMER_WITH_DROP_OLDEST_QUEUE_MACROS_SVH
`define LINE_FRAMER_WITH_DROP_OLDEST_QUEUE_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define LFQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("line framer check failed");

// condition in this cycle implies consequence in the next cycle
`define LFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("line framer check failed");

`endif

/* rtl/lfq_pkg.sv */
// shared types, codes and defaults for the line framer with drop-oldest queue
// no dependencies; every rtl module imports this package
package lfq_pkg;

    localparam int LINE_CAPACITY_DEF  = 4;
    localparam int MAX_LINE_BYTES_DEF = 8192;

    localparam int              LIMIT_W     = 14;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd8192;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // entries of the command queue between front and back
    localparam int CMD_Q_DEPTH = 2;

    typedef enum logic [2:0] {
        ST_STORED      = 3'd0,
        ST_QUEUED      = 3'd1,
        ST_QUEUED_DROP = 3'd2,
        ST_EMPTY_TERM  = 3'd3,
        ST_OVERFLOW    = 3'd4,
        ST_READ        = 3'd5,
        ST_QEMPTY      = 3'd6
    } t_status;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        t_status    status;
        logic [7:0] out_byte;
        logic       last_of_line;
        logic [2:0] lines_waiting;
    } t_out_word;

    // classified item as handed from front to back
    typedef struct packed {
        t_status    status;
        logic       last;
        logic [2:0] lines;
        logic [7:0] data;
    } t_cmd_info;

    localparam int CMD_INFO_W = $bits(t_cmd_info);

endpackage

/* rtl/lfq_fifo.sv */
// short command queue between the classifying front and the memory back
// depends on lfq_pkg for its depth
module lfq_fifo #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop
);
    import lfq_pkg::*;

    localparam int PTR_W = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_Q_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_Q_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMD_Q_DEPTH);

    logic [W-1:0]     r_data [CMD_Q_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_data[r_rptr];

endmodule

/* rtl/lfq_front.sv */
// front: accepts words, holds all line and queue bookkeeping, classifies each word
// depends on lfq_pkg; feeds lfq_fifo with a classified command and a byte address
module lfq_front #(
    parameter int   LINE_CAPACITY  = lfq_pkg::LINE_CAPACITY_DEF,
    parameter int   MAX_LINE_BYTES = lfq_pkg::MAX_LINE_BYTES_DEF,
    localparam int  ADDR_W = $clog2(LINE_CAPACITY + 1) + $clog2(MAX_LINE_BYTES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lfq_pkg::LIMIT_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lfq_pkg::t_in_word             i_in_word,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output lfq_pkg::t_cmd_info            o_cmd_info,
    output logic [ADDR_W-1:0]             o_cmd_addr
);
    import lfq_pkg::*;

    localparam int SLOT_W = $clog2(LINE_CAPACITY + 1);
    localparam int OFF_W  = $clog2(MAX_LINE_BYTES);
    localparam int LEN_W  = $clog2(MAX_LINE_BYTES + 1);
    localparam int CNT_W  = $clog2(LINE_CAPACITY + 1);
    localparam int CMP_W  = (LEN_W > LIMIT_W) ? LEN_W : LIMIT_W;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(LINE_CAPACITY);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(LINE_CAPACITY);
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_LINE_BYTES);

    // one spare physical slot: the line being assembled never shares a slot
    // with a queued line, so no copy is needed when a line completes
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
    endfunction

    logic [LIMIT_W-1:0] r_limit;
    logic [LEN_W-1:0]   r_asm_len,   n_asm_len;
    logic [SLOT_W-1:0]  r_asm_slot,  n_asm_slot;
    logic [SLOT_W-1:0]  r_head_slot, n_head_slot;
    logic [CNT_W-1:0]   r_count,     n_count;
    logic [OFF_W-1:0]   r_roff,      n_roff;
    // lengths of queued lines, oldest at entry zero
    logic [LEN_W-1:0]   r_len [LINE_CAPACITY];
    logic [LEN_W-1:0]   n_len [LINE_CAPACITY];

    logic      w_accept;
    logic      w_is_term;
    logic      w_at_limit;
    logic      w_full;
    logic      w_last_rd;
    t_cmd_info w_info;
    logic [ADDR_W-1:0] w_addr;

    assign w_accept   = i_in_valid && !i_q_full;
    assign w_is_term  = (i_in_word.data_byte == CH_LF) || (i_in_word.data_byte == CH_CR);
    assign w_at_limit = (CMP_W'(r_asm_len) >= CMP_W'(r_limit)) || (r_asm_len >= LEN_MAX);
    assign w_full     = (r_count == CNT_FULL);
    assign w_last_rd  = (LEN_W'(r_roff) + LEN_W'(1)) >= r_len[0];

    always_comb begin
        n_asm_len   = r_asm_len;
        n_asm_slot  = r_asm_slot;
        n_head_slot = r_head_slot;
        n_count     = r_count;
        n_roff      = r_roff;
        n_len       = r_len;
        w_info      = '{status: ST_STORED, last: 1'b0, lines: 3'd0, data: 8'd0};
        w_addr      = '0;

        if (i_in_word.mode == MODE_PUSH) begin
            if (w_is_term) begin
                if (r_asm_len != '0) begin
                    if (w_full) begin
                        // drop the oldest line to make room
                        w_info.status = ST_QUEUED_DROP;
                        n_head_slot   = slot_inc(r_head_slot);
                        n_roff        = '0;
                        for (int i = 0; i < LINE_CAPACITY - 1; i++) begin
                            n_len[i] = r_len[i+1];
                        end
                        n_len[LINE_CAPACITY-1] = r_asm_len;
                    end else begin
                        w_info.status = ST_QUEUED;
                        for (int i = 0; i < LINE_CAPACITY; i++) begin
                            if (CNT_W'(i) == r_count) begin
                                n_len[i] = r_asm_len;
                            end
                        end
                        n_count = r_count + CNT_W'(1);
                    end
                    n_asm_slot = slot_inc(r_asm_slot);
                    n_asm_len  = '0;
                end else begin
                    w_info.status = ST_EMPTY_TERM;
                end
            end else if (w_at_limit) begin
                w_info.status = ST_OVERFLOW;
                n_asm_len     = '0;
            end else begin
                w_info.status = ST_STORED;
                w_info.data   = i_in_word.data_byte;
                w_addr        = {r_asm_slot, OFF_W'(r_asm_len)};
                n_asm_len     = r_asm_len + LEN_W'(1);
            end
        end else if (r_count == '0) begin
            w_info.status = ST_QEMPTY;
        end else begin
            w_info.status = ST_READ;
            w_addr        = {r_head_slot, r_roff};
            if (w_last_rd) begin
                w_info.last = 1'b1;
                n_head_slot = slot_inc(r_head_slot);
                n_count     = r_count - CNT_W'(1);
                n_roff      = '0;
                for (int i = 0; i < LINE_CAPACITY - 1; i++) begin
                    n_len[i] = r_len[i+1];
                end
            end else begin
                n_roff = r_roff + OFF_W'(1);
            end
        end

        w_info.lines = 3'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_asm_len   <= '0;
            r_asm_slot  <= '0;
            r_head_slot <= '0;
            r_count     <= '0;
            r_roff      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (w_accept) begin
                r_asm_len   <= n_asm_len;
                r_asm_slot  <= n_asm_slot;
                r_head_slot <= n_head_slot;
                r_count     <= n_count;
                r_roff      <= n_roff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_len <= n_len;
        end
    end

    assign o_in_stall = i_q_full;
    assign o_q_push   = w_accept;
    assign o_cmd_info = w_info;
    assign o_cmd_addr = w_addr;

endmodule

/* rtl/lfq_back.sv */
// back: carries out byte writes and reads on the line store, drives the result register
// depends on lfq_pkg; takes commands from lfq_fifo
module lfq_back #(
    parameter int ADDR_W = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  lfq_pkg::t_cmd_info   i_cmd_info,
    input  logic [ADDR_W-1:0]    i_cmd_addr,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lfq_pkg::t_out_word   o_out_word
);
    import lfq_pkg::*;

    localparam int MEM_DEPTH = 1 << ADDR_W;

    // line store: one row of bytes per physical slot
    logic [7:0] r_mem [MEM_DEPTH];
    logic [7:0] r_rdata;
    t_cmd_info  r_info;
    logic       r_valid;
    logic       w_advance;
    logic       w_pop;

    assign w_advance = !r_valid || !i_out_stall;
    assign w_pop     = w_advance && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_advance) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_info <= i_cmd_info;
            if (i_cmd_info.status == ST_STORED) begin
                r_mem[i_cmd_addr] <= i_cmd_info.data;
            end
            r_rdata <= r_mem[i_cmd_addr];
        end
    end

    always_comb begin
        o_out_word.status        = r_info.status;
        o_out_word.out_byte      = (r_info.status == ST_READ) ? r_rdata : 8'd0;
        o_out_word.last_of_line  = r_info.last;
        o_out_word.lines_waiting = r_info.lines;
    end

    assign o_q_pop     = w_pop;
    assign o_out_valid = r_valid;

endmodule

/* rtl/line_framer_with_drop_oldest_queue.sv */
// top level of the line framer with drop-oldest line queue
// depends on lfq_pkg, lfq_front, lfq_fifo and lfq_back
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+------------------------
//   in       | input     | i_in_valid / o_in_stall   | i_in_word   (t_in_word)
//   out      | output    | o_out_valid / i_out_stall | o_out_word  (t_out_word)
//   cfg      | input     | i_cfg_we                  | i_cfg_data  (line limit)
//
// one word accepted per cycle unless the command queue is full, one result word
// per cycle unless the output stalls; a word is classified and queued at its
// accepting edge; its store access loads the result register when it is popped
// the line store has a single port and one access per word, which sets the rate
// reset is synchronous and takes effect at once; store contents are not cleared
// an output stall holds the result register; o_in_stall rises once the two-entry
// command queue is full, after one or two more words
module line_framer_with_drop_oldest_queue #(
    parameter int LINE_CAPACITY  = lfq_pkg::LINE_CAPACITY_DEF,
    parameter int MAX_LINE_BYTES = lfq_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lfq_pkg::LIMIT_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  lfq_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output lfq_pkg::t_out_word          o_out_word
);
    import lfq_pkg::*;

    localparam int ADDR_W = $clog2(LINE_CAPACITY + 1) + $clog2(MAX_LINE_BYTES);
    localparam int CMD_W  = CMD_INFO_W + ADDR_W;

    logic              w_q_full;
    logic              w_q_push;
    logic              w_q_valid;
    logic              w_q_pop;
    t_cmd_info         w_front_info;
    logic [ADDR_W-1:0] w_front_addr;
    logic [CMD_W-1:0]  w_q_wdata;
    logic [CMD_W-1:0]  w_q_rdata;
    t_cmd_info         w_back_info;
    logic [ADDR_W-1:0] w_back_addr;

    lfq_front #(
        .LINE_CAPACITY  (LINE_CAPACITY),
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_cmd_info (w_front_info),
        .o_cmd_addr (w_front_addr)
    );

    assign w_q_wdata = {w_front_info, w_front_addr};

    lfq_fifo #(
        .W (CMD_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata),
        .i_pop   (w_q_pop)
    );

    assign w_back_info = t_cmd_info'(w_q_rdata[CMD_W-1:ADDR_W]);
    assign w_back_addr = w_q_rdata[ADDR_W-1:0];

    lfq_back #(
        .ADDR_W (ADDR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_cmd_info  (w_back_info),
        .i_cmd_addr  (w_back_addr),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

/* rtl/lfq_checker.sv */
// port-level checks for the line framer, attached to the top level by bind
// depends on lfq_pkg and line_framer_with_drop_oldest_queue_macros.svh
`include "line_framer_with_drop_oldest_queue_macros.svh"

module lfq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input lfq_pkg::t_out_word o_out_word
);
    import lfq_pkg::*;

    logic w_held;
    logic w_not_held;
    logic w_not_read;
    logic w_no_extras;
    logic w_qempty;

    assign w_held      = o_out_valid && i_out_stall;
    assign w_not_held  = !o_out_valid || !i_out_stall;
    assign w_not_read  = o_out_valid && (o_out_word.status != ST_READ);
    assign w_no_extras = (o_out_word.out_byte == 8'd0) && !o_out_word.last_of_line;
    assign w_qempty    = o_out_valid && (o_out_word.status == ST_QEMPTY);

    // a held result keeps its content
    `LFQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_held, o_out_valid && $stable(o_out_word))

    // only a read result carries a byte or a last flag
    `LFQ_ASSERT_SAME(a_byte_only_on_read, i_clk, i_rst_n, w_not_read, w_no_extras)

    // an empty queue report leaves no lines waiting
    `LFQ_ASSERT_SAME(a_empty_no_lines, i_clk, i_rst_n, w_qempty, o_out_word.lines_waiting == 3'd0)

    // the input side can stall only directly after a hold of the output side
    `LFQ_ASSERT_NEXT(a_stall_needs_hold, i_clk, i_rst_n, w_not_held, !o_in_stall)

endmodule

bind line_framer_with_drop_oldest_queue lfq_checker u_lfq_checker (.*);

/* dv/line_framer_with_drop_oldest_queue_tb.sv */
// testbench for the line framer with drop-oldest line queue: a directed table,
// then random push/read traffic under several line limits, checked per field
// depends on lfq_pkg and line_framer_with_drop_oldest_queue
module line_framer_with_drop_oldest_queue_tb;
    import lfq_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int CAP         = LINE_CAPACITY_DEF;
    localparam int MAX_BYTES   = MAX_LINE_BYTES_DEF;

    localparam t_out_word NO_REPLY = '0;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       known;
        t_out_word  reply;
    } t_dir_row;

    localparam int DIR_ROWS = 22;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        {MODE_READ, 8'h5A, 1'b1, ST_QEMPTY,      8'h00, 1'b0, 3'd0},
        {MODE_PUSH, CH_LF, 1'b1, ST_EMPTY_TERM,  8'h00, 1'b0, 3'd0},
        {MODE_PUSH, CH_CR, 1'b1, ST_EMPTY_TERM,  8'h00, 1'b0, 3'd0},
        {MODE_PUSH, 8'h00, 1'b1, ST_STORED,      8'h00, 1'b0, 3'd0},
        {MODE_PUSH, 8'hFF, 1'b1, ST_STORED,      8'h00, 1'b0, 3'd0},
        {MODE_PUSH, CH_CR, 1'b1, ST_QUEUED,      8'h00, 1'b0, 3'd1},
        // partial read of the first line, later dropped
        {MODE_READ, 8'hFF, 1'b1, ST_READ,        8'h00, 1'b0, 3'd1},
        {MODE_PUSH, 8'h41, 1'b0, NO_REPLY},
        {MODE_PUSH, CH_LF, 1'b1, ST_QUEUED,      8'h00, 1'b0, 3'd2},
        {MODE_PUSH, 8'h8A, 1'b0, NO_REPLY},
        {MODE_PUSH, 8'h8D, 1'b0, NO_REPLY},
        {MODE_PUSH, 8'h0B, 1'b0, NO_REPLY},
        {MODE_PUSH, CH_CR, 1'b1, ST_QUEUED,      8'h00, 1'b0, 3'd3},
        {MODE_PUSH, 8'h0C, 1'b0, NO_REPLY},
        {MODE_PUSH, CH_LF, 1'b1, ST_QUEUED,      8'h00, 1'b0, 3'd4},
        {MODE_PUSH, 8'h7F, 1'b0, NO_REPLY},
        {MODE_PUSH, CH_CR, 1'b1, ST_QUEUED_DROP, 8'h00, 1'b0, 3'd4},
        // read offset restarts on the new head after the drop
        {MODE_READ, 8'h00, 1'b1, ST_READ,        8'h41, 1'b1, 3'd3},
        {MODE_READ, 8'h00, 1'b0, NO_REPLY},
        {MODE_READ, 8'h00, 1'b0, NO_REPLY},
        {MODE_READ, 8'h00, 1'b0, NO_REPLY},
        {MODE_READ, 8'h00, 1'b0, NO_REPLY}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [LIMIT_W-1:0]   cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    t_in_word             in_word   = '0;
    logic                 out_stall = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    t_out_word            out_word;

    // framer state as the block should hold it
    logic [LIMIT_W-1:0]   line_limit = LIMIT_RESET;
    logic [7:0]           asm_buf [MAX_BYTES];
    int unsigned          asm_len    = 0;
    logic [7:0]           slot_mem [CAP][MAX_BYTES];
    int unsigned          slot_len [CAP];
    int unsigned          head_slot  = 0;
    int unsigned          tail_slot  = 0;
    int unsigned          lines_held = 0;
    int unsigned          read_pos   = 0;

    t_out_word            reply_words [$];
    t_out_word            head_reply;
    int unsigned          status_hits [8];
    int unsigned          words_sent  = 0;
    int unsigned          fault_count = 0;
    int unsigned          cycle_count = 0;
    int unsigned          idle_pct    = 14;

    line_framer_with_drop_oldest_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // one framer step on the local state; returns the reply word
    function automatic t_out_word framer_step(input t_in_word w);
        t_out_word   r;
        int unsigned lim;
        int unsigned n;
        r = '0;
        lim = (line_limit > MAX_BYTES) ? MAX_BYTES : line_limit;
        if (w.mode == MODE_PUSH) begin
            if (w.data_byte == CH_LF || w.data_byte == CH_CR) begin
                if (asm_len > 0) begin
                    n = (asm_len > MAX_BYTES) ? MAX_BYTES : asm_len;
                    if (lines_held >= CAP) begin
                        head_slot = (head_slot + 1) % CAP;
                        lines_held--;
                        read_pos = 0;
                        r.status = ST_QUEUED_DROP;
                    end else begin
                        r.status = ST_QUEUED;
                    end
                    for (int i = 0; i < n; i++) slot_mem[tail_slot][i] = asm_buf[i];
                    slot_len[tail_slot] = n;
                    tail_slot = (tail_slot + 1) % CAP;
                    lines_held++;
                    asm_len = 0;
                end else begin
                    r.status = ST_EMPTY_TERM;
                end
            end else if (asm_len >= lim) begin
                asm_len = 0;
                r.status = ST_OVERFLOW;
            end else begin
                asm_buf[asm_len % MAX_BYTES] = w.data_byte;
                asm_len++;
                r.status = ST_STORED;
            end
        end else if (lines_held == 0) begin
            r.status = ST_QEMPTY;
        end else begin
            r.status = ST_READ;
            r.out_byte = slot_mem[head_slot][read_pos];
            if (read_pos + 1 >= slot_len[head_slot]) begin
                r.last_of_line = 1'b1;
                head_slot = (head_slot + 1) % CAP;
                lines_held--;
                read_pos = 0;
            end else begin
                read_pos++;
            end
        end
        r.lines_waiting = lines_held[2:0];
        return r;
    endfunction

    // offer one word, wait for it to be taken, record its reply
    task automatic send_word(input t_in_word w, input bit pinned = 1'b0,
                             input t_out_word pinned_reply = '0);
        t_out_word r;
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        r = framer_step(w);
        status_hits[r.status]++;
        if (r.status != ST_EMPTY_TERM) words_sent++;
        reply_words.push_back(pinned ? pinned_reply : r);
    endtask

    task automatic settle_queue();
        in_valid <= 1'b0;
        while (reply_words.size() != 0) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        settle_queue();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        line_limit = v;
        @(posedge clk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_LF || b == CH_CR) b = b ^ 8'h40;
        return b;
    endfunction

    // mostly whole lines and read bursts, some raw noise
    task automatic run_traffic(input int unsigned n_words);
        int unsigned stop_at;
        int unsigned lim;
        int unsigned cap;
        int unsigned pick;
        logic [7:0]  term;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            lim = (line_limit > MAX_BYTES) ? MAX_BYTES : line_limit;
            if (pick < 45) begin
                cap = (lim > 24) ? 24 : lim;
                repeat ($urandom_range(0, cap + 1)) send_word({MODE_PUSH, plain_byte()});
                term = ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
                send_word({MODE_PUSH, term});
                // cr lf pair: the second terminator finds an empty buffer
                if ($urandom_range(0, 4) == 0) send_word({MODE_PUSH, term ^ 8'h07});
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 10))
                    send_word({MODE_READ, 8'($urandom_range(0, 255))});
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    term = ($urandom_range(0, 3) == 0) ? CH_LF : 8'($urandom_range(0, 255));
                    send_word({1'($urandom_range(0, 1)), term});
                end
            end
        end
    endtask

    // result side: compare each word taken, then pick the next stall
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (reply_words.size() == 0) begin
                $error("result word with nothing pending: %h", out_word);
                fault_count++;
            end else begin
                head_reply = reply_words.pop_front();
                if (out_word.status !== head_reply.status) begin
                    $error("status: expected %0d, got %0d",
                           head_reply.status, out_word.status);
                    fault_count++;
                end
                if (out_word.out_byte !== head_reply.out_byte) begin
                    $error("out_byte: expected %h, got %h",
                           head_reply.out_byte, out_word.out_byte);
                    fault_count++;
                end
                if (out_word.last_of_line !== head_reply.last_of_line) begin
                    $error("last_of_line: expected %0d, got %0d",
                           head_reply.last_of_line, out_word.last_of_line);
                    fault_count++;
                end
                if (out_word.lines_waiting !== head_reply.lines_waiting) begin
                    $error("lines_waiting: expected %0d, got %0d",
                           head_reply.lines_waiting, out_word.lines_waiting);
                    fault_count++;
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_word({DIR_TABLE[i].mode, DIR_TABLE[i].data_byte},
                      DIR_TABLE[i].known, DIR_TABLE[i].reply);
        end

        run_traffic(100);
        write_limit(14'd1);
        run_traffic(150);
        write_limit(14'd0);
        run_traffic(100);
        write_limit(14'd3);
        run_traffic(150);

        // lowering the limit below a partly built line
        write_limit(14'd12);
        send_word({MODE_PUSH, CH_CR});
        repeat (10) send_word({MODE_PUSH, plain_byte()});
        write_limit(14'd4);
        send_word({MODE_PUSH, plain_byte()});
        run_traffic(150);

        // saturated limit, no idling on either side
        idle_pct = 0;
        write_limit(14'h3FFF);
        run_traffic(150);
        idle_pct = 14;

        write_limit(14'd6);
        run_traffic(150);
        write_limit(14'd8192);
        run_traffic(150);
        write_limit(14'd2);
        run_traffic(100);

        settle_queue();
        repeat (6) @(posedge clk);

        $display("framer run: %0d words under line limits from 0 to 16383", words_sent);
        $display("lines queued %0d, oldest dropped %0d, overflows %0d, bytes read %0d",
                 status_hits[ST_QUEUED], status_hits[ST_QUEUED_DROP],
                 status_hits[ST_OVERFLOW], status_hits[ST_READ]);
        if (fault_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lfq_pkg.sv
rtl/lfq_fifo.sv
rtl/lfq_front.sv
rtl/lfq_back.sv
rtl/line_framer_with_drop_oldest_queue.sv
rtl/lfq_checker.sv
dv/line_framer_with_drop_oldest_queue_tb.sv
